// ===== hdl/dlmip_pkg.sv =====
package dlmip_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_DESC  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    // Attribute numbers
    localparam logic [7:0] ATTR_POS_MTX  = 8'd0;
    localparam logic [7:0] ATTR_TEX7_MTX = 8'd8;
    localparam logic [7:0] ATTR_CLR0     = 8'd11;
    localparam logic [7:0] ATTR_CLR1     = 8'd12;
    localparam logic [7:0] ATTR_TEX7     = 8'd20;
    localparam logic [7:0] ATTR_END      = 8'hFF;

    // Attribute storage types
    localparam logic [1:0] ATYPE_IDX8  = 2'd2;
    localparam logic [1:0] ATYPE_IDX16 = 2'd3;

    // Color component formats
    localparam logic [2:0] COMP_RGB565 = 3'd0;
    localparam logic [2:0] COMP_RGB8   = 3'd1;
    localparam logic [2:0] COMP_RGBX8  = 3'd2;
    localparam logic [2:0] COMP_RGBA4  = 3'd3;
    localparam logic [2:0] COMP_RGBA6  = 3'd4;

    // Bytes whose top five bits are clear are NOPs in command position
    localparam logic [7:0] CMD_MASK = 8'hF8;

    localparam logic [7:0] STRIDE_MAX = 8'hFF;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic [7:0] attribute;
        logic [1:0] attribute_type;
        logic [2:0] component_type;
    } desc_cmd_t;

    typedef struct packed {
        logic [7:0] stride;
        logic [7:0] src_off;
        logic       src_valid;
        logic [7:0] dst_off;
        logic       dst_valid;
    } desc_info_t;

    // Byte size of one attribute in a vertex
    function automatic logic [2:0] attr_size(input logic [7:0] attr,
                                             input logic [1:0] atype,
                                             input logic [2:0] ctype);
        logic [2:0] sz;
        sz = 3'd0;
        if (attr <= ATTR_TEX7_MTX) begin
            sz = 3'd1;
        end else if (attr == ATTR_CLR0 || attr == ATTR_CLR1) begin
            if (atype == ATYPE_IDX16) begin
                sz = 3'd2;
            end else if (atype == ATYPE_IDX8) begin
                sz = 3'd1;
            end else begin
                case (ctype)
                    COMP_RGB565, COMP_RGBA4: sz = 3'd2;
                    COMP_RGB8, COMP_RGBA6:   sz = 3'd3;
                    COMP_RGBX8:              sz = 3'd4;
                    default:                 sz = 3'd0;
                endcase
            end
        end else if (attr <= ATTR_TEX7) begin
            sz = (atype == ATYPE_IDX16) ? 3'd2 : 3'd1;
        end
        return sz;
    endfunction

endpackage

// ===== hdl/dlmip_desc.sv =====
// Vertex layout tracker: stride and matrix index offsets from descriptors.
module dlmip_desc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dlmip_pkg::desc_cmd_t   cmd,
    output dlmip_pkg::desc_info_t  info
);

    dlmip_pkg::desc_info_t info_reg;
    dlmip_pkg::desc_info_t info_next;
    logic                  done_reg;
    logic                  done_next;
    logic [8:0]            sum;

    always_comb
    begin
        info_next = info_reg;
        done_next = done_reg;
        sum = {1'b0, info_reg.stride}
            + {6'd0, dlmip_pkg::attr_size(cmd.attribute, cmd.attribute_type,
                                          cmd.component_type)};
        if (cmd.clear) begin
            info_next = '0;
            done_next = 1'b0;
        end else if (cmd.load && !done_reg) begin
            if (cmd.attribute == dlmip_pkg::ATTR_END) begin
                done_next = 1'b1;
            end else begin
                if (cmd.attribute == dlmip_pkg::ATTR_POS_MTX) begin
                    info_next.src_off   = info_reg.stride;
                    info_next.src_valid = 1'b1;
                end else if (cmd.attribute <= dlmip_pkg::ATTR_TEX7_MTX) begin
                    info_next.dst_off   = info_reg.stride;
                    info_next.dst_valid = 1'b1;
                end
                // saturate
                info_next.stride = sum[8] ? dlmip_pkg::STRIDE_MAX : sum[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            info_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            info_reg <= info_next;
            done_reg <= done_next;
        end
    end

    assign info = info_reg;

endmodule

// ===== hdl/display_list_matrix_index_patcher.sv =====
// Display list matrix index patcher. Send a begin item, then the object's
// vertex attribute descriptors (attribute 255 ends the list), then the display
// list one byte per transfer. Every display list byte comes back as exactly one
// result transfer; begin and descriptor items give none. Inside the vertex data
// of each draw command the position-matrix index byte is copied over the last
// texture-matrix index byte when patch_enable is set, both offsets exist and
// the texture offset lies after the position offset. Throughput is one item
// per clock while the output is not stalled. Each item passes an input
// register and a result register before it reaches the output. A stalled
// result holds the input register, which then stalls the input. The whole
// per-byte update (phase, counters, compare, select) sits in the logic
// between those two registers. Write patch_enable only while idle.
module display_list_matrix_index_patcher (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] attribute,
    input  logic [1:0] attribute_type,
    input  logic [2:0] component_type,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       patched
);

    typedef enum logic [1:0] {
        PH_CMD,
        PH_CNT_HI,
        PH_CNT_LO,
        PH_VERTEX
    } phase_t;

    logic       patch_enable_reg;

    // input register
    logic       s1_valid_reg;
    logic [1:0] s1_kind_reg;
    logic [7:0] s1_attr_reg;
    logic [1:0] s1_atype_reg;
    logic [2:0] s1_ctype_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] vleft_reg, vleft_next;
    logic [7:0]  biv_reg, biv_next;
    logic [7:0]  held_reg, held_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       patched_reg, patched_next;

    logic                  advance;
    logic                  s1_accept;
    logic [8:0]            biv_inc;
    logic [15:0]           vcount;
    dlmip_pkg::desc_cmd_t  desc_cmd;
    dlmip_pkg::desc_info_t desc;

    // Output slot frees when empty or being taken; the input register moves on then.
    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign s1_accept = in_valid && !in_stall;

    assign desc_cmd.clear          = advance && s1_valid_reg
                                     && s1_kind_reg == dlmip_pkg::KIND_BEGIN;
    assign desc_cmd.load           = advance && s1_valid_reg
                                     && s1_kind_reg == dlmip_pkg::KIND_DESC;
    assign desc_cmd.attribute      = s1_attr_reg;
    assign desc_cmd.attribute_type = s1_atype_reg;
    assign desc_cmd.component_type = s1_ctype_reg;

    dlmip_desc u_desc (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (desc_cmd),
        .info (desc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            patch_enable_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_accept)
        begin
            s1_kind_reg  <= kind;
            s1_attr_reg  <= attribute;
            s1_atype_reg <= attribute_type;
            s1_ctype_reg <= component_type;
            s1_data_reg  <= data_byte;
            s1_last_reg  <= is_last;
        end
    end

    // Per-byte parse and patch
    always_comb
    begin
        phase_next     = phase_reg;
        vleft_next     = vleft_reg;
        biv_next       = biv_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        patched_next   = patched_reg;
        biv_inc        = {1'b0, biv_reg} + 9'd1;
        vcount         = {vleft_reg[15:8], s1_data_reg};

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (s1_valid_reg && s1_kind_reg == dlmip_pkg::KIND_BEGIN)
            begin
                phase_next = PH_CMD;
                vleft_next = '0;
                biv_next   = '0;
                held_next  = '0;
            end
            else if (s1_valid_reg && s1_kind_reg == dlmip_pkg::KIND_BYTE)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = s1_data_reg;
                out_last_next  = s1_last_reg;
                patched_next   = 1'b0;
                case (phase_reg)
                    PH_CMD:
                    begin
                        if ((s1_data_reg & dlmip_pkg::CMD_MASK) != 8'd0)
                        begin
                            phase_next = PH_CNT_HI;
                        end
                    end
                    PH_CNT_HI:
                    begin
                        vleft_next = {s1_data_reg, 8'd0};
                        phase_next = PH_CNT_LO;
                    end
                    PH_CNT_LO:
                    begin
                        vleft_next = vcount;
                        biv_next   = '0;
                        phase_next = (vcount == 16'd0 || desc.stride == 8'd0)
                                     ? PH_CMD : PH_VERTEX;
                    end
                    PH_VERTEX:
                    begin
                        if (desc.src_valid && biv_reg == desc.src_off)
                        begin
                            held_next = s1_data_reg;
                        end
                        if (patch_enable_reg && desc.src_valid && desc.dst_valid
                            && desc.dst_off > desc.src_off && biv_reg == desc.dst_off)
                        begin
                            out_byte_next = held_reg;
                            patched_next  = 1'b1;
                        end
                        if (biv_inc >= {1'b0, desc.stride})
                        begin
                            biv_next   = '0;
                            vleft_next = vleft_reg - 16'd1;
                            if (vleft_reg == 16'd1)
                            begin
                                phase_next = PH_CMD;
                            end
                        end
                        else
                        begin
                            biv_next = biv_inc[7:0];
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
                // end of list: back to command position
                if (s1_last_reg)
                begin
                    phase_next = PH_CMD;
                    vleft_next = '0;
                    biv_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            vleft_reg     <= '0;
            biv_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            patched_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            vleft_reg     <= vleft_next;
            biv_reg       <= biv_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            patched_reg   <= patched_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign patched   = patched_reg;

    // Vertex phase is entered only with a nonzero stride; only a begin item clears stride
    a_vertex_stride: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VERTEX |-> desc.stride != 8'd0)
        else $error("vertex phase with zero stride");

    a_biv_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VERTEX |-> biv_reg < desc.stride)
        else $error("byte-in-vertex beyond stride");

    a_patch_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && patched_reg |-> desc.src_valid && desc.dst_valid)
        else $error("patched byte without both offsets");

    a_patch_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && patched_reg |-> out_byte_reg == held_reg)
        else $error("patched byte differs from held source byte");

endmodule
